// ===== hw/rtl/rdbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdbm_pkg
// Shared types and codes for the region-decoded big-endian byte memory.
// ----------------------------------------------------------------------------

package rdbm_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned TAG_W    = 12;
    localparam int unsigned OFS_W    = 20;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SIZE_W   = 2;

    // region tags, address bits 31..20
    localparam logic [TAG_W-1:0] TAG_PROGRAM = 12'h004;
    localparam logic [TAG_W-1:0] TAG_DATA    = 12'h100;
    localparam logic [TAG_W-1:0] TAG_STACK   = 12'h7FF;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_REGION  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd2;

    localparam logic [SIZE_W-1:0] SZ_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_HALF = 2'd1;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        RG_PROGRAM,
        RG_DATA,
        RG_STACK
    } t_region;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_QR,
        S_RED,
        S_BYTE,
        S_TAIL,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/region_decoded_byte_memory_top.sv =====
`timescale 1ns / 1ps
// Sequence: a no-region or misaligned word goes from accept to S_DONE; a good access
//   of n bytes (n = 1, 2 or 4) runs S_MUL, S_QR, S_RED, S_BYTE per byte, S_TAIL, S_DONE.
// Throughput: one word at a time (o_stall until S_IDLE); the single byte port of the store
//   RAM moves one byte a cycle, after a three-stage offset reduction modulo REGION_BYTES.
// Reset: control and handshake state clear; the store RAM is not cleared and
//   holds undefined bytes until written.
// ----------------------------------------------------------------------------
// region_decoded_byte_memory_top
// Program, data and stack byte stores in one synchronous RAM, big-endian,
// with region decode and alignment check.
// ----------------------------------------------------------------------------

module region_decoded_byte_memory_top #(
    parameter int unsigned REGION_BYTES = 1048576
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_action,
    input  logic [rdbm_pkg::ADDR_W-1:0]    i_address,
    input  logic [rdbm_pkg::DATA_W-1:0]    i_write_data,
    input  logic [rdbm_pkg::SIZE_W-1:0]    i_access_size,
    // response channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rdbm_pkg::DATA_W-1:0]    o_read_data,
    output logic [rdbm_pkg::STATUS_W-1:0]  o_status
);

    localparam int unsigned OFS_W    = rdbm_pkg::OFS_W;
    localparam int unsigned IDX_W    = $clog2(REGION_BYTES);
    localparam int unsigned MEM_D    = 3 * REGION_BYTES;
    localparam int unsigned MA_W     = $clog2(MEM_D);
    localparam int unsigned RSHIFT   = 40;
    localparam longint unsigned RECIP = (64'd1 << RSHIFT) / REGION_BYTES;
    localparam int unsigned RECIP_W  = $clog2(RECIP + 1);
    localparam int unsigned PROD_W   = OFS_W + RECIP_W;
    localparam int unsigned Q_W      = $clog2((64'd1 << OFS_W) / REGION_BYTES + 2);
    localparam int unsigned QR_W     = Q_W + IDX_W + 1;
    localparam int unsigned R_W      = OFS_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [IDX_W:0]     RB_C    = (IDX_W+1)'(REGION_BYTES);
    localparam logic [IDX_W-1:0]   IDX_MAX = IDX_W'(REGION_BYTES - 1);
    localparam logic [MA_W-1:0]    BASE_DATA  = MA_W'(REGION_BYTES);
    localparam logic [MA_W-1:0]    BASE_STACK = MA_W'(2 * REGION_BYTES);
    localparam int unsigned BW     = rdbm_pkg::BYTE_W;
    localparam int unsigned DW     = rdbm_pkg::DATA_W;

    rdbm_pkg::t_state  r_state, n_state;

    logic [rdbm_pkg::BYTE_W-1:0] mem [MEM_D];
    logic [BW-1:0]                r_mem_q;

    // item registers
    logic                          r_action;
    logic [OFS_W-1:0]              r_offset;
    logic [DW-1:0]                 r_wdata;
    logic [1:0]                    r_left;
    logic [MA_W-1:0]               r_base;
    logic [PROD_W-1:0]             r_prod;
    logic [QR_W-1:0]               r_qr;
    logic [IDX_W-1:0]              r_idx;
    logic [DW-1:0]                 r_acc;
    logic [rdbm_pkg::STATUS_W-1:0] r_status;
    logic                          r_rd_pend;

    // output register
    logic                          r_out_valid;
    logic [DW-1:0]                 r_out_data;
    logic [rdbm_pkg::STATUS_W-1:0] r_out_status;

    // request decode
    logic [rdbm_pkg::TAG_W-1:0]    in_tag;
    logic [OFS_W-1:0]              in_ofs;
    logic                          in_hit;
    rdbm_pkg::t_region             in_region;
    logic                          in_misaligned;
    logic [1:0]                    in_left;
    logic [DW-1:0]                 in_wdata;
    logic [rdbm_pkg::STATUS_W-1:0] in_status;
    logic [MA_W-1:0]               in_base;

    // control
    logic                          accept;
    logic                          mem_en;
    logic                          mem_we;
    logic                          load_out;
    logic [Q_W-1:0]                q_est;
    logic [R_W-1:0]                rem_raw;
    logic [R_W-1:0]                rem_fix;
    logic [IDX_W-1:0]              idx_next;
    logic [MA_W-1:0]               mem_addr;

    always_comb begin
        in_tag = i_address[rdbm_pkg::ADDR_W-1 -: rdbm_pkg::TAG_W];
        in_ofs = i_address[OFS_W-1:0];
        in_hit = 1'b1;
        in_region = rdbm_pkg::RG_PROGRAM;
        in_base = '0;
        if (in_tag == rdbm_pkg::TAG_PROGRAM) begin
            in_region = rdbm_pkg::RG_PROGRAM;
        end else if (in_tag == rdbm_pkg::TAG_DATA) begin
            in_region = rdbm_pkg::RG_DATA;
        end else if (in_tag == rdbm_pkg::TAG_STACK) begin
            in_region = rdbm_pkg::RG_STACK;
        end else begin
            in_hit = 1'b0;
        end
        case (in_region)
            rdbm_pkg::RG_DATA:  in_base = BASE_DATA;
            rdbm_pkg::RG_STACK: in_base = BASE_STACK;
            default:            in_base = '0;
        endcase
        // size code three behaves as a word
        case (i_access_size)
            rdbm_pkg::SZ_BYTE: begin
                in_misaligned = 1'b0;
                in_left       = 2'd0;
                in_wdata      = i_write_data << (3 * BW);
            end
            rdbm_pkg::SZ_HALF: begin
                in_misaligned = in_ofs[0];
                in_left       = 2'd1;
                in_wdata      = i_write_data << (2 * BW);
            end
            default: begin
                in_misaligned = |in_ofs[1:0];
                in_left       = 2'd3;
                in_wdata      = i_write_data;
            end
        endcase
        if (!in_hit) begin
            in_status = rdbm_pkg::ST_NO_REGION;
        end else if (in_misaligned) begin
            in_status = rdbm_pkg::ST_MISALIGNED;
        end else begin
            in_status = rdbm_pkg::ST_OK;
        end
    end

    // offset mod REGION_BYTES: reciprocal estimate is low by at most one
    always_comb begin
        q_est    = Q_W'(r_prod >> RSHIFT);
        rem_raw  = R_W'(r_offset) - R_W'(r_qr);
        rem_fix  = (rem_raw >= R_W'(RB_C)) ? rem_raw - R_W'(RB_C) : rem_raw;
        idx_next = (r_idx == IDX_MAX) ? '0 : r_idx + 1'b1;
        mem_addr = r_base + MA_W'(r_idx);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rdbm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = (in_status == rdbm_pkg::ST_OK) ? rdbm_pkg::S_MUL
                                                             : rdbm_pkg::S_DONE;
                end
            end
            rdbm_pkg::S_MUL:  n_state = rdbm_pkg::S_QR;
            rdbm_pkg::S_QR:   n_state = rdbm_pkg::S_RED;
            rdbm_pkg::S_RED:  n_state = rdbm_pkg::S_BYTE;
            rdbm_pkg::S_BYTE: begin
                if (r_left == 2'd0) begin
                    n_state = rdbm_pkg::S_TAIL;
                end
            end
            rdbm_pkg::S_TAIL: n_state = rdbm_pkg::S_DONE;
            rdbm_pkg::S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = rdbm_pkg::S_IDLE;
                end
            end
            default: n_state = rdbm_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall  = (r_state != rdbm_pkg::S_IDLE);
        accept   = i_valid && (r_state == rdbm_pkg::S_IDLE);
        mem_en   = (r_state == rdbm_pkg::S_BYTE);
        mem_we   = mem_en && (r_action == rdbm_pkg::ACT_WRITE);
        load_out = (r_state == rdbm_pkg::S_DONE) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (mem_en) begin
            if (mem_we) begin
                mem[mem_addr] <= r_wdata[DW-1 -: BW];
            end
            r_mem_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdbm_pkg::S_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= mem_en && (r_action == rdbm_pkg::ACT_READ);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_offset <= in_ofs;
            r_wdata  <= in_wdata;
            r_left   <= in_left;
            r_base   <= in_base;
            r_status <= in_status;
            r_acc    <= '0;
        end else begin
            if (r_rd_pend) begin
                r_acc <= {r_acc[DW-BW-1:0], r_mem_q};
            end
            if (mem_en) begin
                r_wdata <= r_wdata << BW;
                r_left  <= r_left - 1'b1;
            end
        end
        case (r_state)
            rdbm_pkg::S_MUL:  r_prod <= PROD_W'(r_offset) * PROD_W'(RECIP_C);
            rdbm_pkg::S_QR:   r_qr   <= QR_W'(q_est) * QR_W'(RB_C);
            rdbm_pkg::S_RED:  r_idx  <= rem_fix[IDX_W-1:0];
            rdbm_pkg::S_BYTE: r_idx  <= idx_next;
            default: ;
        endcase
        if (load_out) begin
            r_out_data   <= r_acc;
            r_out_status <= r_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;

endmodule
